/* rtl/bpfa_pkg.sv */
// Shared types, codes and counter helpers for the bitmap page frame allocator.
// No dependencies; used by bpfa_engine and bitmap_page_frame_allocator_core.
package bpfa_pkg;

	localparam int PAGE_W  = 16;
	localparam int COUNT_W = 17;
	localparam int SUM_W   = COUNT_W + 1;

	localparam logic [COUNT_W-1:0] COUNT_MAX   = 17'h1FFFF;
	localparam logic [COUNT_W-1:0] TOTAL_RESET = 17'h10000;

	localparam logic [2:0] OP_ALLOC_ONE = 3'd0;
	localparam logic [2:0] OP_ALLOC_RUN = 3'd1;
	localparam logic [2:0] OP_FREE      = 3'd2;
	localparam logic [2:0] OP_LOCK      = 3'd3;
	localparam logic [2:0] OP_RESERVE   = 3'd4;
	localparam logic [2:0] OP_UNRESERVE = 3'd5;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_OOM   = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [2:0]         op;
		logic [PAGE_W-1:0]  page;
		logic [COUNT_W-1:0] count;
	} cmd_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [PAGE_W-1:0]  page_out;
		logic [COUNT_W-1:0] free_pages;
		logic [COUNT_W-1:0] used_pages;
		logic [COUNT_W-1:0] reserved_pages;
	} rsp_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_HINT,
		S_SEARCH,
		S_TAKE,
		S_RUN,
		S_FILL,
		S_DONE
	} state_t;

	function automatic logic [COUNT_W-1:0] cnt_inc(input logic [COUNT_W-1:0] c);
		cnt_inc = (c == COUNT_MAX) ? c : c + 1'b1;
	endfunction

	function automatic logic [COUNT_W-1:0] cnt_dec(input logic [COUNT_W-1:0] c);
		cnt_dec = (c == '0) ? c : c - 1'b1;
	endfunction

endpackage

/* rtl/bitmap_page_frame_allocator_core.sv */
// Top level of the bitmap page frame allocator: size register, result register, bitmap RAM.
// Depends on bpfa_pkg, bpfa_ram and bpfa_engine.
//
// Use: send one command per cmd transaction (op, page, count); each returns exactly one
// rsp transaction with status, the allocated page and the free, used and reserved counts.
// cfg_data sets the number of tracked pages; a write clears the whole allocator.
// A command walks its pages one per cycle while they lie in the one-word cache; a page
// outside it first brings its bitmap word in over the single RAM read port, writing the
// cached word back if it changed. One command is in flight at a time.
// Reset and every cfg write start a clearing pass over all bitmap words during which
// cmd_ready is low.
// The result waits in an output register; while the receiver stalls, the next command
// is still taken and runs up to its result, which then waits for the register.
// WORD_BITS must be a power of two.
module bitmap_page_frame_allocator_core #(
	parameter int MAX_PAGES = 65536,
	parameter int WORD_BITS = 32
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  bpfa_pkg::cmd_t               cmd,
	output logic                         rsp_valid,
	input  logic                         rsp_ready,
	output bpfa_pkg::rsp_t               rsp,
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [bpfa_pkg::COUNT_W-1:0] cfg_data
);

	localparam int DEPTH   = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
	localparam int WADDR_W = $clog2(DEPTH);
	localparam logic [bpfa_pkg::COUNT_W-1:0] MAXP =
		(MAX_PAGES > 131071) ? bpfa_pkg::COUNT_MAX : bpfa_pkg::COUNT_W'(MAX_PAGES);

	logic [bpfa_pkg::COUNT_W-1:0] total_q, lim;
	logic                         init, res_valid, slot_free, rsp_valid_q;
	bpfa_pkg::rsp_t               res, rsp_q;
	logic                         ram_we;
	logic [WADDR_W-1:0]           ram_waddr, ram_raddr;
	logic [WORD_BITS-1:0]         ram_wdata, ram_rdata;

	// size register
	assign cfg_ready = 1'b1;
	assign init      = cfg_valid && cfg_ready;
	assign lim       = (total_q > MAXP) ? MAXP : total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= bpfa_pkg::TOTAL_RESET;
		end else if (init) begin
			total_q <= cfg_data;
		end
	end

	bpfa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	bpfa_engine #(
		.WORD_BITS (WORD_BITS),
		.DEPTH     (DEPTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.init      (init),
		.lim       (lim),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res       (res),
		.slot_free (slot_free),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_raddr (ram_raddr),
		.ram_rdata (ram_rdata)
	);

	// output register: load a finished result, drop it when taken
	assign slot_free = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && slot_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && slot_free) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTH
	// a size write starts the clearing pass
	a_cfg_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_ready |=> !cmd_ready)
		else $error("command accepted right after size write");

	// one command in flight
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready |=> !cmd_ready)
		else $error("second command accepted while busy");

	// failed commands report no page
	a_fail_page: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != bpfa_pkg::ST_OK |-> rsp.page_out == '0)
		else $error("page reported on failed command");
`endif

endmodule

/* rtl/bpfa_ram.sv */
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module bpfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write and read, read data registered
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* rtl/bpfa_engine.sv */
// Command sequencer: walks pages one per cycle while they hit a one-word bitmap cache.
// Depends on bpfa_pkg.
module bpfa_engine #(
	parameter int WORD_BITS = 32,
	parameter int DEPTH     = 2048
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          init,
	input  logic [bpfa_pkg::COUNT_W-1:0]  lim,
	input  logic                          cmd_valid,
	output logic                          cmd_ready,
	input  bpfa_pkg::cmd_t                cmd,
	output logic                          res_valid,
	output bpfa_pkg::rsp_t                res,
	input  logic                          slot_free,
	output logic                          ram_we,
	output logic [$clog2(DEPTH)-1:0]      ram_waddr,
	output logic [WORD_BITS-1:0]          ram_wdata,
	output logic [$clog2(DEPTH)-1:0]      ram_raddr,
	input  logic [WORD_BITS-1:0]          ram_rdata
);

	localparam int WADDR_W = $clog2(DEPTH);
	localparam int BIT_W   = $clog2(WORD_BITS);
	localparam int CW      = bpfa_pkg::COUNT_W;
	localparam int SW      = bpfa_pkg::SUM_W;

	bpfa_pkg::state_t state_q, state_d, ret_q, ret_d;
	bpfa_pkg::cmd_t   cmd_q, cmd_d;
	logic [CW-1:0]    p_q, p_d, s_q, s_d, n_q, n_d, hint_q, hint_d;
	logic [CW-1:0]    free_q, free_d, used_q, used_d, resv_q, resv_d;
	logic [WORD_BITS-1:0] cache_q, cache_d;
	logic [WADDR_W-1:0]   caddr_q, caddr_d, clr_q, clr_d;
	logic             cvalid_q, cvalid_d, dirty_q, dirty_d, post_q, post_d;
	logic [1:0]       status_q, status_d;
	logic [CW-1:0]    pout_q, pout_d;

	logic [CW-1:0]      ptr;
	logic [WADDR_W-1:0] wsel;
	logic [BIT_W-1:0]   bsel;
	logic               hit, cur, last;
	logic [SW-1:0]      run_end;

	// current page pointer and its place in the cache
	always_comb begin
		if (state_q == bpfa_pkg::S_HINT ||
			(state_q == bpfa_pkg::S_FILL && ret_q == bpfa_pkg::S_HINT)) begin
			ptr = hint_q;
		end else begin
			ptr = p_q;
		end
		wsel    = WADDR_W'(ptr >> BIT_W);
		bsel    = ptr[BIT_W-1:0];
		hit     = cvalid_q && (caddr_q == wsel);
		cur     = cache_q[bsel];
		last    = (n_q + 1'b1) == cmd_q.count;
		run_end = SW'(cmd.page) + SW'(cmd.count);
	end

	assign cmd_ready = (state_q == bpfa_pkg::S_IDLE);
	assign res_valid = (state_q == bpfa_pkg::S_DONE);
	assign res       = '{status: status_q, page_out: pout_q[bpfa_pkg::PAGE_W-1:0],
		free_pages: free_q, used_pages: used_q, reserved_pages: resv_q};
	assign ram_raddr = wsel;

	// next state, datapath updates and RAM controls
	always_comb begin
		state_d  = state_q;
		ret_d    = ret_q;
		cmd_d    = cmd_q;
		p_d      = p_q;
		s_d      = s_q;
		n_d      = n_q;
		hint_d   = hint_q;
		free_d   = free_q;
		used_d   = used_q;
		resv_d   = resv_q;
		cache_d  = cache_q;
		caddr_d  = caddr_q;
		clr_d    = clr_q;
		cvalid_d = cvalid_q;
		dirty_d  = dirty_q;
		post_d   = post_q;
		status_d = status_q;
		pout_d   = pout_q;
		ram_we    = 1'b0;
		ram_waddr = caddr_q;
		ram_wdata = cache_q;

		unique case (state_q)
			bpfa_pkg::S_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '0;
				clr_d     = clr_q + 1'b1;
				if (clr_q == WADDR_W'(DEPTH - 1)) begin
					free_d  = lim;
					state_d = bpfa_pkg::S_IDLE;
				end
			end
			bpfa_pkg::S_IDLE: begin
				if (cmd_valid) begin
					cmd_d    = cmd;
					status_d = bpfa_pkg::ST_OK;
					pout_d   = '0;
					post_d   = 1'b0;
					p_d      = CW'(cmd.page);
					n_d      = '0;
					case (cmd.op) inside
						bpfa_pkg::OP_ALLOC_ONE, bpfa_pkg::OP_ALLOC_RUN: begin
							state_d = bpfa_pkg::S_HINT;
						end
						bpfa_pkg::OP_FREE: begin
							if (cmd.page == '0 || cmd.count == '0) begin
								state_d = bpfa_pkg::S_DONE;
							end else if (run_end > SW'(lim)) begin
								status_d = bpfa_pkg::ST_RANGE;
								state_d  = bpfa_pkg::S_DONE;
							end else begin
								state_d = bpfa_pkg::S_RUN;
							end
						end
						bpfa_pkg::OP_LOCK, bpfa_pkg::OP_RESERVE, bpfa_pkg::OP_UNRESERVE: begin
							if (run_end > SW'(lim)) begin
								status_d = bpfa_pkg::ST_RANGE;
								state_d  = bpfa_pkg::S_DONE;
							end else if (cmd.count == '0) begin
								state_d = bpfa_pkg::S_DONE;
							end else begin
								state_d = bpfa_pkg::S_RUN;
							end
						end
						default: begin
							state_d = bpfa_pkg::S_DONE;
						end
					endcase
				end
			end
			bpfa_pkg::S_HINT: begin
				if (hint_q >= lim) begin
					if (!post_q) begin
						status_d = bpfa_pkg::ST_OOM;
					end
					state_d = bpfa_pkg::S_DONE;
				end else if (!hit) begin
					ret_d   = state_q;
					state_d = bpfa_pkg::S_FILL;
					ram_we  = dirty_q;
				end else if (cur) begin
					hint_d = hint_q + 1'b1;
				end else if (post_q) begin
					state_d = bpfa_pkg::S_DONE;
				end else if (cmd_q.op == bpfa_pkg::OP_ALLOC_ONE) begin
					cache_d[bsel] = 1'b1;
					dirty_d = 1'b1;
					free_d  = bpfa_pkg::cnt_dec(free_q);
					used_d  = bpfa_pkg::cnt_inc(used_q);
					pout_d  = hint_q;
					state_d = bpfa_pkg::S_DONE;
				end else if (cmd_q.count == '0) begin
					pout_d  = hint_q;
					state_d = bpfa_pkg::S_DONE;
				end else begin
					s_d = hint_q;
					p_d = hint_q;
					n_d = '0;
					if (SW'(hint_q) + SW'(cmd_q.count) > SW'(lim)) begin
						status_d = bpfa_pkg::ST_OOM;
						state_d  = bpfa_pkg::S_DONE;
					end else begin
						state_d = bpfa_pkg::S_SEARCH;
					end
				end
			end
			bpfa_pkg::S_SEARCH: begin
				if (!hit) begin
					ret_d   = state_q;
					state_d = bpfa_pkg::S_FILL;
					ram_we  = dirty_q;
				end else if (cur) begin
					// blocked: restart the candidate just past this page
					if (SW'(p_q) + 1'b1 + SW'(cmd_q.count) > SW'(lim)) begin
						status_d = bpfa_pkg::ST_OOM;
						state_d  = bpfa_pkg::S_DONE;
					end else begin
						p_d = p_q + 1'b1;
						s_d = p_q + 1'b1;
						n_d = '0;
					end
				end else if (last) begin
					p_d     = s_q;
					n_d     = '0;
					state_d = bpfa_pkg::S_TAKE;
				end else begin
					p_d = p_q + 1'b1;
					n_d = n_q + 1'b1;
				end
			end
			bpfa_pkg::S_TAKE: begin
				if (!hit) begin
					ret_d   = state_q;
					state_d = bpfa_pkg::S_FILL;
					ram_we  = dirty_q;
				end else begin
					if (!cur) begin
						cache_d[bsel] = 1'b1;
						dirty_d = 1'b1;
						free_d  = bpfa_pkg::cnt_dec(free_q);
						used_d  = bpfa_pkg::cnt_inc(used_q);
					end
					if (last) begin
						pout_d  = s_q;
						post_d  = 1'b1;
						state_d = bpfa_pkg::S_HINT;
					end else begin
						p_d = p_q + 1'b1;
						n_d = n_q + 1'b1;
					end
				end
			end
			bpfa_pkg::S_RUN: begin
				if (!hit) begin
					ret_d   = state_q;
					state_d = bpfa_pkg::S_FILL;
					ram_we  = dirty_q;
				end else begin
					if (last) begin
						state_d = bpfa_pkg::S_DONE;
					end else begin
						p_d = p_q + 1'b1;
						n_d = n_q + 1'b1;
					end
					case (cmd_q.op)
						bpfa_pkg::OP_FREE: begin
							if (cur) begin
								cache_d[bsel] = 1'b0;
								dirty_d = 1'b1;
								free_d  = bpfa_pkg::cnt_inc(free_q);
								used_d  = bpfa_pkg::cnt_dec(used_q);
								if (hint_q > p_q) begin
									hint_d = p_q;
								end
							end
						end
						bpfa_pkg::OP_LOCK: begin
							if (!cur) begin
								cache_d[bsel] = 1'b1;
								dirty_d = 1'b1;
								free_d  = bpfa_pkg::cnt_dec(free_q);
								used_d  = bpfa_pkg::cnt_inc(used_q);
							end
						end
						bpfa_pkg::OP_RESERVE: begin
							if (cur) begin
								state_d = bpfa_pkg::S_DONE;
							end else begin
								cache_d[bsel] = 1'b1;
								dirty_d = 1'b1;
								free_d  = bpfa_pkg::cnt_dec(free_q);
								resv_d  = bpfa_pkg::cnt_inc(resv_q);
							end
						end
						default: begin
							if (!cur) begin
								state_d = bpfa_pkg::S_DONE;
							end else begin
								cache_d[bsel] = 1'b0;
								dirty_d = 1'b1;
								free_d  = bpfa_pkg::cnt_inc(free_q);
								resv_d  = bpfa_pkg::cnt_dec(resv_q);
								if (hint_q > p_q) begin
									hint_d = p_q;
								end
							end
						end
					endcase
				end
			end
			bpfa_pkg::S_FILL: begin
				cache_d  = ram_rdata;
				caddr_d  = wsel;
				cvalid_d = 1'b1;
				dirty_d  = 1'b0;
				state_d  = ret_q;
			end
			bpfa_pkg::S_DONE: begin
				if (slot_free) begin
					state_d = bpfa_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = bpfa_pkg::S_IDLE;
			end
		endcase

		// size change: start over with an empty bitmap
		if (init) begin
			state_d  = bpfa_pkg::S_CLEAR;
			clr_d    = '0;
			cvalid_d = 1'b0;
			dirty_d  = 1'b0;
			hint_d   = '0;
			used_d   = '0;
			resv_d   = '0;
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bpfa_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ret_q    <= bpfa_pkg::S_IDLE;
			clr_q    <= '0;
			cvalid_q <= 1'b0;
			dirty_q  <= 1'b0;
			post_q   <= 1'b0;
			hint_q   <= '0;
			free_q   <= '0;
			used_q   <= '0;
			resv_q   <= '0;
		end else begin
			ret_q    <= ret_d;
			clr_q    <= clr_d;
			cvalid_q <= cvalid_d;
			dirty_q  <= dirty_d;
			post_q   <= post_d;
			hint_q   <= hint_d;
			free_q   <= free_d;
			used_q   <= used_d;
			resv_q   <= resv_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		cmd_q    <= cmd_d;
		p_q      <= p_d;
		s_q      <= s_d;
		n_q      <= n_d;
		cache_q  <= cache_d;
		caddr_q  <= caddr_d;
		status_q <= status_d;
		pout_q   <= pout_d;
	end

endmodule

/* sim/tb.sv */
// Self-checking testbench for bitmap_page_frame_allocator_core.
// Depends on bpfa_pkg and the allocator RTL; keeps its own copy of the page bitmap and counters.
`timescale 1ns / 1ps

module tb;

	localparam int NPAGES   = 65536;
	localparam int WD_LIMIT = 1000000;

	logic        clk;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_ready;
	bpfa_pkg::cmd_t cmd;
	logic        rsp_valid;
	logic        rsp_ready;
	bpfa_pkg::rsp_t rsp;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [bpfa_pkg::COUNT_W-1:0] cfg_data;

	// page frame shadow state
	bit          page_taken [NPAGES];
	int unsigned hint_pg, free_cnt, used_cnt, rsvd_cnt, size_reg;

	bpfa_pkg::rsp_t rsp_expected [$];
	int          fail_cnt;
	int          cmd_cnt;
	int          rsp_cnt;
	int          idle_cnt;
	bit          send_gaps;
	bit          recv_stalls;
	int          gap_pct;

	bitmap_page_frame_allocator_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic int unsigned eff_size();
		return (size_reg > NPAGES) ? NPAGES : size_reg;
	endfunction

	function automatic bit is_taken(int unsigned i);
		if (i >= NPAGES)
			return 1'b1;
		return page_taken[i];
	endfunction

	function automatic int unsigned sat_inc(int unsigned c);
		return (c >= 32'(bpfa_pkg::COUNT_MAX)) ? c : c + 1;
	endfunction

	function automatic int unsigned sat_dec(int unsigned c);
		return (c == 0) ? 0 : c - 1;
	endfunction

	function automatic void clear_frames(int unsigned sz);
		foreach (page_taken[i])
			page_taken[i] = 1'b0;
		size_reg = sz;
		hint_pg  = 0;
		free_cnt = eff_size();
		used_cnt = 0;
		rsvd_cnt = 0;
	endfunction

	function automatic void mark_used(int unsigned i);
		if (!is_taken(i)) begin
			page_taken[i] = 1'b1;
			free_cnt = sat_dec(free_cnt);
			used_cnt = sat_inc(used_cnt);
		end
	endfunction

	function automatic void skip_taken(int unsigned lim);
		while (hint_pg < lim && is_taken(hint_pg))
			hint_pg++;
	endfunction

	// apply one command to the shadow allocator and build the response it should give
	function automatic bpfa_pkg::rsp_t frame_alloc_apply(bpfa_pkg::cmd_t c);
		int unsigned lim, st, pout, pg, n, s, blocked, p;
		bit          found, t;
		bpfa_pkg::rsp_t r;
		lim  = eff_size();
		st   = 32'(bpfa_pkg::ST_OK);
		pout = 0;
		pg   = {16'b0, c.page};
		n    = {15'b0, c.count};
		if (c.op == bpfa_pkg::OP_ALLOC_ONE) begin
			skip_taken(lim);
			if (hint_pg >= lim)
				st = 32'(bpfa_pkg::ST_OOM);
			else begin
				pout = hint_pg;
				mark_used(hint_pg);
			end
		end else if (c.op == bpfa_pkg::OP_ALLOC_RUN) begin
			skip_taken(lim);
			if (hint_pg >= lim)
				st = 32'(bpfa_pkg::ST_OOM);
			else if (n == 0)
				pout = hint_pg;
			else begin
				s = hint_pg;
				found = 1'b0;
				while (s + n <= lim) begin
					blocked = lim;
					for (int unsigned i = 0; i < n; i++) begin
						if (is_taken(s + i)) begin
							blocked = s + i;
							break;
						end
					end
					if (blocked == lim) begin
						found = 1'b1;
						break;
					end
					s = blocked + 1;
				end
				if (found) begin
					pout = s;
					for (int unsigned i = 0; i < n; i++)
						mark_used(s + i);
					skip_taken(lim);
				end else
					st = 32'(bpfa_pkg::ST_OOM);
			end
		end else if (c.op inside {bpfa_pkg::OP_FREE, bpfa_pkg::OP_LOCK,
			bpfa_pkg::OP_RESERVE, bpfa_pkg::OP_UNRESERVE}) begin
			if (c.op == bpfa_pkg::OP_FREE && (pg == 0 || n == 0)) begin
				// ignored, reports ok
			end else if (pg + n > lim)
				st = 32'(bpfa_pkg::ST_RANGE);
			else begin
				for (int unsigned i = 0; i < n; i++) begin
					p = pg + i;
					t = is_taken(p);
					if (c.op == bpfa_pkg::OP_FREE) begin
						if (t) begin
							page_taken[p] = 1'b0;
							free_cnt = sat_inc(free_cnt);
							used_cnt = sat_dec(used_cnt);
							if (hint_pg > p)
								hint_pg = p;
						end
					end else if (c.op == bpfa_pkg::OP_LOCK)
						mark_used(p);
					else if (c.op == bpfa_pkg::OP_RESERVE) begin
						if (t)
							break;
						page_taken[p] = 1'b1;
						free_cnt = sat_dec(free_cnt);
						rsvd_cnt = sat_inc(rsvd_cnt);
					end else begin
						if (!t)
							break;
						page_taken[p] = 1'b0;
						free_cnt = sat_inc(free_cnt);
						rsvd_cnt = sat_dec(rsvd_cnt);
						if (hint_pg > p)
							hint_pg = p;
					end
				end
			end
		end
		r.status         = st[1:0];
		r.page_out       = pout[bpfa_pkg::PAGE_W-1:0];
		r.free_pages     = free_cnt[bpfa_pkg::COUNT_W-1:0];
		r.used_pages     = used_cnt[bpfa_pkg::COUNT_W-1:0];
		r.reserved_pages = rsvd_cnt[bpfa_pkg::COUNT_W-1:0];
		return r;
	endfunction

	// drive one command transaction and record its expected response
	task automatic send_cmd(logic [2:0] op, int unsigned pg, int unsigned n);
		bpfa_pkg::cmd_t c;
		c.op    = op;
		c.page  = pg[bpfa_pkg::PAGE_W-1:0];
		c.count = n[bpfa_pkg::COUNT_W-1:0];
		while (send_gaps && $urandom_range(99) < gap_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd       <= c;
		do @(negedge clk); while (!cmd_ready);
		@(posedge clk);
		rsp_expected.push_back(frame_alloc_apply(c));
		cmd_cnt++;
	endtask

	// wait until every response is back, then let the block settle
	task automatic drain();
		cmd_valid <= 1'b0;
		while (rsp_expected.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_size(int unsigned sz);
		drain();
		cfg_valid <= 1'b1;
		cfg_data  <= sz[bpfa_pkg::COUNT_W-1:0];
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 1'b0;
		clear_frames(sz);
	endtask

	task automatic set_idling(int mode);
		send_gaps   = (mode == 1 || mode == 3);
		recv_stalls = (mode == 2 || mode == 3);
		gap_pct     = (mode == 3) ? 35 : 45;
	endtask

	// hold rsp_ready low at random while stalling is on
	always @(posedge clk) begin
		if (!arst_n)
			rsp_ready <= 1'b0;
		else
			rsp_ready <= recv_stalls ? ($urandom_range(99) >= gap_pct) : 1'b1;
	end

	// check each response transaction against the oldest expectation
	always @(negedge clk) begin
		bpfa_pkg::rsp_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			rsp_cnt++;
			if (rsp_expected.size() == 0) begin
				$error("unexpected response transaction");
				fail_cnt++;
			end else begin
				e = rsp_expected.pop_front();
				if (rsp.status !== e.status) begin
					$error("status expected %0d got %0d", e.status, rsp.status);
					fail_cnt++;
				end
				if (rsp.page_out !== e.page_out) begin
					$error("page_out expected %0d got %0d", e.page_out, rsp.page_out);
					fail_cnt++;
				end
				if (rsp.free_pages !== e.free_pages) begin
					$error("free_pages expected %0d got %0d", e.free_pages, rsp.free_pages);
					fail_cnt++;
				end
				if (rsp.used_pages !== e.used_pages) begin
					$error("used_pages expected %0d got %0d", e.used_pages, rsp.used_pages);
					fail_cnt++;
				end
				if (rsp.reserved_pages !== e.reserved_pages) begin
					$error("reserved_pages expected %0d got %0d", e.reserved_pages,
						rsp.reserved_pages);
					fail_cnt++;
				end
			end
		end
	end

	// end the run when nothing moves for too long
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WD_LIMIT) begin
			$display("watchdog expired");
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic test_directed_full();
		send_cmd(bpfa_pkg::OP_ALLOC_ONE, 0, 0);
		send_cmd(bpfa_pkg::OP_ALLOC_RUN, 0, 5);
		send_cmd(bpfa_pkg::OP_ALLOC_RUN, 0, 0);
		send_cmd(bpfa_pkg::OP_FREE, 2, 2);
		send_cmd(bpfa_pkg::OP_LOCK, 10, 3);
		send_cmd(bpfa_pkg::OP_RESERVE, 20, 4);
		send_cmd(bpfa_pkg::OP_RESERVE, 21, 2);
		send_cmd(bpfa_pkg::OP_UNRESERVE, 20, 6);
		send_cmd(bpfa_pkg::OP_FREE, 0, 3);
		send_cmd(bpfa_pkg::OP_FREE, 5, 0);
		send_cmd(bpfa_pkg::OP_LOCK, 65535, 1);
		send_cmd(bpfa_pkg::OP_RESERVE, 65535, 2);
		send_cmd(bpfa_pkg::OP_FREE, 100, 65536);
		send_cmd(3'd6, 65535, 65536);
		send_cmd(3'd7, 1234, 7);
		send_cmd(bpfa_pkg::OP_ALLOC_RUN, 0, 65536);
		send_cmd(bpfa_pkg::OP_LOCK, 0, 65536);
		send_cmd(bpfa_pkg::OP_ALLOC_ONE, 0, 0);
		send_cmd(bpfa_pkg::OP_FREE, 1, 65535);
		send_cmd(bpfa_pkg::OP_ALLOC_RUN, 0, 3);
	endtask

	task automatic test_single_page();
		write_size(1);
		send_cmd(bpfa_pkg::OP_ALLOC_ONE, 0, 0);
		send_cmd(bpfa_pkg::OP_ALLOC_ONE, 0, 0);
		send_cmd(bpfa_pkg::OP_ALLOC_RUN, 0, 0);
		send_cmd(bpfa_pkg::OP_ALLOC_RUN, 0, 1);
		send_cmd(bpfa_pkg::OP_FREE, 0, 1);
		send_cmd(bpfa_pkg::OP_RESERVE, 0, 1);
		send_cmd(bpfa_pkg::OP_UNRESERVE, 0, 2);
	endtask

	// mostly in-range commands with short runs; a few long counts that overrun the size
	task automatic test_random(int unsigned sz, int n_items);
		int unsigned pg, n, lim, sel;
		logic [2:0]  op;
		write_size(sz);
		lim = eff_size();
		for (int k = 0; k < n_items; k++) begin
			if (k % 40 == 0)
				set_idling((k / 40) % 5 == 4 ? 0 : (k / 40) % 4);
			sel = $urandom_range(99);
			if (sel < 25)      op = bpfa_pkg::OP_ALLOC_ONE;
			else if (sel < 40) op = bpfa_pkg::OP_ALLOC_RUN;
			else if (sel < 65) op = bpfa_pkg::OP_FREE;
			else if (sel < 75) op = bpfa_pkg::OP_LOCK;
			else if (sel < 86) op = bpfa_pkg::OP_RESERVE;
			else if (sel < 97) op = bpfa_pkg::OP_UNRESERVE;
			else               op = 3'($urandom_range(7, 6));
			pg = ($urandom_range(9) == 0) ? $urandom_range(65535) : $urandom_range(lim - 1);
			n  = $urandom_range(16);
			if ($urandom_range(49) == 0) begin
				n = $urandom_range(65536);
				if (n > 64 && pg + n <= lim)
					pg = lim - n + 1;
			end
			send_cmd(op, pg, n);
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cmd_valid = 1'b0;
		cmd       = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		cmd_cnt   = 0;
		set_idling(0);
		clear_frames(32'(bpfa_pkg::TOTAL_RESET));
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_full();
		test_single_page();
		test_random(200, 150);
		test_random(65536, 150);
		test_random(37, 120);
		test_random(1000, 130);
		drain();

		$display("%0d commands sent, %0d responses checked", cmd_cnt, rsp_cnt);
		$display("sizes 1, 37, 200, 1000 and 65536 with all ops and idling modes");
		if (fail_cnt == 0 && rsp_expected.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* bitmap_page_frame_allocator_core.f */
rtl/bpfa_pkg.sv
rtl/bpfa_ram.sv
rtl/bpfa_engine.sv
rtl/bitmap_page_frame_allocator_core.sv
sim/tb.sv
